[src/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, codes and command bytes shared by the SD card SPI start-up sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

	// Defaults
	localparam int          DUMMY_BYTES_DEF = 10;
	localparam logic [7:0]  POLL_LIMIT_RST  = 8'd100;

	// Bus byte values and R1 flags
	localparam logic [7:0]  BYTE_FILL   = 8'hFF;
	localparam logic [7:0]  BYTE_NONE   = 8'h00;
	localparam logic [7:0]  R1_IDLE     = 8'h01;
	localparam logic [7:0]  R1_ILLEGAL  = 8'h04;
	localparam logic [7:0]  OCR_CCS     = 8'h40;

	// Command frame and trailing field lengths
	localparam logic [2:0]  CMD_LEN     = 3'd6;
	localparam logic [2:0]  TRAIL_LEN   = 3'd4;

	// Item kind carried in tuser
	localparam logic        MODE_START  = 1'b0;
	localparam logic        MODE_XFER   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_NOT_SD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CT_UNKNOWN = 2'd0,
		CT_SD1     = 2'd1,
		CT_SD2     = 2'd2,
		CT_SDHC    = 2'd3
	} ctype_t;

	typedef enum logic [23:0] {
		PH_IDLE        = 24'h000001,
		PH_DUMMY       = 24'h000002,
		PH_C0_SEND     = 24'h000004,
		PH_C0_POLL     = 24'h000008,
		PH_C0_GAP      = 24'h000010,
		PH_C8_SEND     = 24'h000020,
		PH_C8_POLL     = 24'h000040,
		PH_C8_TRAIL    = 24'h000080,
		PH_C8_GAP      = 24'h000100,
		PH_OCR1_SEND   = 24'h000200,
		PH_OCR1_POLL   = 24'h000400,
		PH_OCR1_TRAIL  = 24'h000800,
		PH_LOOP_GAP    = 24'h001000,
		PH_C55_SEND    = 24'h002000,
		PH_C55_POLL    = 24'h004000,
		PH_C55_GAP     = 24'h008000,
		PH_A41_SEND    = 24'h010000,
		PH_A41_POLL    = 24'h020000,
		PH_OCR2_SEND   = 24'h040000,
		PH_OCR2_POLL   = 24'h080000,
		PH_OCR2_TRAIL  = 24'h100000,
		PH_END_OK      = 24'h200000,
		PH_END_TIMEOUT = 24'h400000,
		PH_END_NOTSD   = 24'h800000
	} phase_t;

	// One result word; tx_byte sits in the low bits
	typedef struct packed {
		ctype_t     card_type;
		status_t    status;
		logic       finished;
		logic       power_enable;
		logic       select_active;
		logic [7:0] tx_byte;
	} result_t;

	// Byte of a command frame; positions past the frame read as fill
	function automatic logic [7:0] cmd_byte(input phase_t ph, input logic [2:0] idx);
		logic [47:0] frame;
		logic [7:0]  b;
		begin
			priority case (ph)
				PH_C0_SEND:                 frame = 48'h40_00_00_00_00_95;
				PH_C8_SEND:                 frame = 48'h48_00_00_01_AA_87;
				PH_OCR1_SEND, PH_OCR2_SEND: frame = 48'h7A_00_00_00_00_FD;
				PH_C55_SEND:                frame = 48'h77_00_00_00_00_65;
				default:                    frame = 48'h69_40_00_00_00_77;
			endcase
			unique case (idx)
				3'd0:    b = frame[47:40];
				3'd1:    b = frame[39:32];
				3'd2:    b = frame[31:24];
				3'd3:    b = frame[23:16];
				3'd4:    b = frame[15:8];
				3'd5:    b = frame[7:0];
				default: b = BYTE_FILL;
			endcase
			return b;
		end
	endfunction

endpackage

[src/sdspi_ctrl.sv]
// ----------------------------------------------------------------------------
// sdspi_ctrl
// Sequencer state and next-state logic; produces the result word for the
// state after the current word.
// ----------------------------------------------------------------------------
module sdspi_ctrl #(
	parameter int DUMMY_BYTES = sdspi_pkg::DUMMY_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                mode,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          poll_limit,
	output sdspi_pkg::result_t  res
);

	sdspi_pkg::phase_t phase_q, phase_d;
	logic [2:0]        bidx_q, bidx_d;
	logic [7:0]        pcnt_q, pcnt_d;
	sdspi_pkg::ctype_t dtype_q, dtype_d;

	logic [8:0]        dummy_inc;
	logic [7:0]        poll_inc;
	logic [2:0]        bidx_inc;
	logic              ended, running, sending;

	assign dummy_inc = {1'b0, pcnt_q} + 9'd1;
	assign poll_inc  = (pcnt_q == 8'hFF) ? pcnt_q : pcnt_q + 8'd1;
	assign bidx_inc  = bidx_q + 3'd1;

	// Next state
	always_comb begin
		phase_d = phase_q;
		bidx_d  = bidx_q;
		pcnt_d  = pcnt_q;
		dtype_d = dtype_q;
		if (mode == sdspi_pkg::MODE_START) begin
			phase_d = sdspi_pkg::PH_DUMMY;
			bidx_d  = 3'd0;
			pcnt_d  = 8'd0;
			dtype_d = sdspi_pkg::CT_UNKNOWN;
		end else begin
			unique case (phase_q)
				sdspi_pkg::PH_DUMMY: begin
					if (dummy_inc >= 9'(DUMMY_BYTES)) begin
						phase_d = sdspi_pkg::PH_C0_SEND;
						pcnt_d  = 8'd0;
						bidx_d  = 3'd0;
					end else begin
						pcnt_d  = dummy_inc[7:0];
					end
				end
				sdspi_pkg::PH_C0_POLL, sdspi_pkg::PH_C8_POLL, sdspi_pkg::PH_OCR1_POLL,
				sdspi_pkg::PH_C55_POLL, sdspi_pkg::PH_A41_POLL,
				sdspi_pkg::PH_OCR2_POLL: begin
					bidx_d = 3'd0;
					pcnt_d = 8'd0;
					if (rx_byte != sdspi_pkg::BYTE_FILL) begin
						// response byte
						unique case (phase_q)
							sdspi_pkg::PH_C0_POLL: begin
								if (rx_byte == sdspi_pkg::R1_IDLE) begin
									phase_d = sdspi_pkg::PH_C0_GAP;
								end else begin
									phase_d = sdspi_pkg::PH_END_NOTSD;
									dtype_d = sdspi_pkg::CT_UNKNOWN;
								end
							end
							sdspi_pkg::PH_C8_POLL: begin
								if ((rx_byte & sdspi_pkg::R1_ILLEGAL) != 8'd0) begin
									phase_d = sdspi_pkg::PH_C8_GAP;
									dtype_d = sdspi_pkg::CT_SD1;
								end else begin
									phase_d = sdspi_pkg::PH_C8_TRAIL;
									dtype_d = sdspi_pkg::CT_UNKNOWN;
								end
							end
							sdspi_pkg::PH_OCR1_POLL, sdspi_pkg::PH_C55_POLL: begin
								if ((rx_byte & sdspi_pkg::R1_ILLEGAL) != 8'd0) begin
									phase_d = sdspi_pkg::PH_END_NOTSD;
									dtype_d = sdspi_pkg::CT_UNKNOWN;
								end else if (phase_q == sdspi_pkg::PH_OCR1_POLL) begin
									phase_d = sdspi_pkg::PH_OCR1_TRAIL;
								end else begin
									phase_d = sdspi_pkg::PH_C55_GAP;
								end
							end
							sdspi_pkg::PH_A41_POLL: begin
								if ((rx_byte & sdspi_pkg::R1_IDLE) != 8'd0)
									phase_d = sdspi_pkg::PH_LOOP_GAP;
								else if (dtype_q == sdspi_pkg::CT_SD1)
									phase_d = sdspi_pkg::PH_END_OK;
								else
									phase_d = sdspi_pkg::PH_OCR2_SEND;
							end
							default: phase_d = sdspi_pkg::PH_OCR2_TRAIL;
						endcase
					end else if (poll_inc >= poll_limit) begin
						phase_d = sdspi_pkg::PH_END_TIMEOUT;
						dtype_d = sdspi_pkg::CT_UNKNOWN;
					end else begin
						bidx_d = bidx_q;
						pcnt_d = poll_inc;
					end
				end
				sdspi_pkg::PH_C8_TRAIL, sdspi_pkg::PH_OCR1_TRAIL,
				sdspi_pkg::PH_OCR2_TRAIL: begin
					// CCS lives in the first OCR byte
					if (phase_q == sdspi_pkg::PH_OCR2_TRAIL && bidx_q == 3'd0)
						dtype_d = ((rx_byte & sdspi_pkg::OCR_CCS) != 8'd0) ?
							sdspi_pkg::CT_SDHC : sdspi_pkg::CT_SD2;
					if (bidx_inc >= sdspi_pkg::TRAIL_LEN) begin
						bidx_d = 3'd0;
						pcnt_d = 8'd0;
						priority case (phase_q)
							sdspi_pkg::PH_C8_TRAIL:   phase_d = sdspi_pkg::PH_C8_GAP;
							sdspi_pkg::PH_OCR1_TRAIL: phase_d = sdspi_pkg::PH_LOOP_GAP;
							default:                  phase_d = sdspi_pkg::PH_END_OK;
						endcase
					end else begin
						bidx_d = bidx_inc;
					end
				end
				sdspi_pkg::PH_C0_GAP, sdspi_pkg::PH_C8_GAP, sdspi_pkg::PH_LOOP_GAP,
				sdspi_pkg::PH_C55_GAP: begin
					bidx_d = 3'd0;
					pcnt_d = 8'd0;
					priority case (phase_q)
						sdspi_pkg::PH_C0_GAP:   phase_d = sdspi_pkg::PH_C8_SEND;
						sdspi_pkg::PH_C8_GAP:   phase_d = sdspi_pkg::PH_OCR1_SEND;
						sdspi_pkg::PH_LOOP_GAP: phase_d = sdspi_pkg::PH_C55_SEND;
						default:                phase_d = sdspi_pkg::PH_A41_SEND;
					endcase
				end
				sdspi_pkg::PH_C0_SEND, sdspi_pkg::PH_C8_SEND, sdspi_pkg::PH_OCR1_SEND,
				sdspi_pkg::PH_C55_SEND, sdspi_pkg::PH_A41_SEND,
				sdspi_pkg::PH_OCR2_SEND: begin
					if (bidx_inc >= sdspi_pkg::CMD_LEN) begin
						bidx_d = 3'd0;
						pcnt_d = 8'd0;
						priority case (phase_q)
							sdspi_pkg::PH_C0_SEND:   phase_d = sdspi_pkg::PH_C0_POLL;
							sdspi_pkg::PH_C8_SEND:   phase_d = sdspi_pkg::PH_C8_POLL;
							sdspi_pkg::PH_OCR1_SEND: phase_d = sdspi_pkg::PH_OCR1_POLL;
							sdspi_pkg::PH_C55_SEND:  phase_d = sdspi_pkg::PH_C55_POLL;
							sdspi_pkg::PH_A41_SEND:  phase_d = sdspi_pkg::PH_A41_POLL;
							default:                 phase_d = sdspi_pkg::PH_OCR2_POLL;
						endcase
					end else begin
						bidx_d = bidx_inc;
					end
				end
				// idle and end phases ignore exchanges
				default: ;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdspi_pkg::PH_IDLE;
			bidx_q  <= 3'd0;
			pcnt_q  <= 8'd0;
			dtype_q <= sdspi_pkg::CT_UNKNOWN;
		end else if (fire) begin
			phase_q <= phase_d;
			bidx_q  <= bidx_d;
			pcnt_q  <= pcnt_d;
			dtype_q <= dtype_d;
		end
	end

	// Result for the state just entered
	assign ended   = (phase_d == sdspi_pkg::PH_END_OK) ||
	                 (phase_d == sdspi_pkg::PH_END_TIMEOUT) ||
	                 (phase_d == sdspi_pkg::PH_END_NOTSD);
	assign running = (phase_d != sdspi_pkg::PH_IDLE) && !ended;
	assign sending = (phase_d == sdspi_pkg::PH_C0_SEND) ||
	                 (phase_d == sdspi_pkg::PH_C8_SEND) ||
	                 (phase_d == sdspi_pkg::PH_OCR1_SEND) ||
	                 (phase_d == sdspi_pkg::PH_C55_SEND) ||
	                 (phase_d == sdspi_pkg::PH_A41_SEND) ||
	                 (phase_d == sdspi_pkg::PH_OCR2_SEND);

	always_comb begin
		if (!running)
			res.tx_byte = sdspi_pkg::BYTE_NONE;
		else if (sending)
			res.tx_byte = sdspi_pkg::cmd_byte(phase_d, bidx_d);
		else
			res.tx_byte = sdspi_pkg::BYTE_FILL;
		res.select_active = running && (phase_d != sdspi_pkg::PH_DUMMY);
		res.power_enable  = running;
		res.finished      = ended;
		if (phase_d == sdspi_pkg::PH_END_TIMEOUT)
			res.status = sdspi_pkg::ST_TIMEOUT;
		else if (phase_d == sdspi_pkg::PH_END_NOTSD)
			res.status = sdspi_pkg::ST_NOT_SD;
		else
			res.status = sdspi_pkg::ST_OK;
		res.card_type = dtype_d;
	end

endmodule

[src/sd_card_spi_init_sequencer.sv]
// ----------------------------------------------------------------------------
// Path: a word accepted on the slave side passes the input register and then
// the result register. Throughput: one word per cycle while the master side
// does not stall; the sequencer state advances in one step.
// Reset: arst_n clears the sequencer to idle, the poll limit to 100 and both
// pipeline stages to empty.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// sd_card_spi_init_sequencer
// Byte-slot sequencer for SD card SPI-mode start-up, with stream handshakes.
// ----------------------------------------------------------------------------
module sd_card_spi_init_sequencer #(
	parameter int DUMMY_BYTES = sdspi_pkg::DUMMY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] mode
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] tx_byte, [8] select_active,
	                               // [9] power_enable, [10] finished,
	                               // [12:11] status, [14:13] card_type
	// configuration
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata  // response_poll_limit
);

	logic               valid_s1;
	logic               mode_s1;
	logic [7:0]         rx_s1;
	logic               m_valid_q;
	sdspi_pkg::result_t res_q;
	sdspi_pkg::result_t res_d;
	logic [7:0]         limit_q;
	logic               out_free, fire;

	assign out_free = !m_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Poll limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= sdspi_pkg::POLL_LIMIT_RST;
		else if (cfg_wen)
			limit_q <= cfg_wdata;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			rx_s1   <= s_tdata;
		end
	end

	// Sequencer
	sdspi_ctrl #(
		.DUMMY_BYTES (DUMMY_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.mode       (mode_s1),
		.rx_byte    (rx_s1),
		.poll_limit (limit_q),
		.res        (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_d;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, res_q};

	// Checks
	a_fire_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_valid_q)
		else $error("processed word did not reach the result register");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

	a_error_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.status != sdspi_pkg::ST_OK) |->
			(res_q.finished && res_q.card_type == sdspi_pkg::CT_UNKNOWN &&
			 !res_q.power_enable))
		else $error("error status without a clean end");

endmodule

[test/tb_sd_card_spi_init_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sd_card_spi_init_sequencer
// Self-checking bench for the SD card SPI start-up sequencer. A scripted card
// answers each byte slot (clean start-ups of every card type, rejected and
// timed-out replies, cut-short runs and line noise). A behavioural predictor
// works out every result word, which is checked field by field against the
// master side under random idling on both streams and several poll limits.
// ----------------------------------------------------------------------------
module tb_sd_card_spi_init_sequencer;
	import sdspi_pkg::*;

	localparam int DUMMY_BYTES = DUMMY_BYTES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 50;
	localparam int SESSION_ANY = 1 << 30;

	// Command frames, one row per command, first byte in the top bits
	localparam int FR_CMD0   = 0;
	localparam int FR_CMD8   = 1;
	localparam int FR_CMD58  = 2;
	localparam int FR_CMD55  = 3;
	localparam int FR_ACMD41 = 4;
	localparam logic [4:0][47:0] CMD_FRAMES = {
		48'h69_40_00_00_00_77,
		48'h77_00_00_00_00_65,
		48'h7A_00_00_00_00_FD,
		48'h48_00_00_01_AA_87,
		48'h40_00_00_00_00_95
	};

	typedef struct packed {
		logic       mode;
		logic [7:0] rx;
	} slot_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;   // [7:0] rx_byte
	logic        s_tuser   = 1'b0;    // [0] mode
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;             // [7:0] tx_byte, [8] select_active,
	                                  // [9] power_enable, [10] finished,
	                                  // [12:11] status, [14:13] card_type
	logic        cfg_wen   = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;

	// Stimulus and scoreboard
	slot_t   slots_to_send[$];
	result_t results_due[$];
	int      items_queued = 0;
	int      items_taken  = 0;
	int      sess_left    = SESSION_ANY;
	int      mismatches   = 0;
	int      cycle_count  = 0;
	int      in_gap       = 0;
	int      out_stall    = 0;
	bit      in_taken     = 1'b0;
	bit      calm         = 1'b0;

	// Predictor state and its copy of the poll limit
	phase_t     seq_phase  = PH_IDLE;
	logic [3:0] slot_idx   = 4'd0;
	logic [7:0] poll_cnt   = 8'd0;
	ctype_t     card_kind  = CT_UNKNOWN;
	logic [7:0] poll_limit = POLL_LIMIT_RST;

	sd_card_spi_init_sequencer #(
		.DUMMY_BYTES(DUMMY_BYTES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void enter_phase(input phase_t p);
		seq_phase = p;
		slot_idx  = 4'd0;
		poll_cnt  = 8'd0;
	endfunction

	function automatic void end_with_error(input phase_t p);
		card_kind = CT_UNKNOWN;
		enter_phase(p);
	endfunction

	function automatic bit is_end(input phase_t p);
		return p == PH_END_OK || p == PH_END_TIMEOUT || p == PH_END_NOTSD;
	endfunction

	// One byte slot: advance the sequence and build the result word
	function automatic result_t step_sequencer(input logic mode, input logic [7:0] rx);
		result_t word;
		logic    running;
		int      row;
		if (mode == MODE_START) begin
			card_kind = CT_UNKNOWN;
			enter_phase(PH_DUMMY);
		end else if (seq_phase != PH_IDLE && !is_end(seq_phase)) begin
			case (seq_phase)
				PH_DUMMY: begin
					poll_cnt++;
					if (poll_cnt >= DUMMY_BYTES)
						enter_phase(PH_C0_SEND);
				end
				PH_C0_POLL, PH_C8_POLL, PH_OCR1_POLL,
				PH_C55_POLL, PH_A41_POLL, PH_OCR2_POLL: begin
					if (rx == BYTE_FILL) begin
						// fill byte: count it, saturating
						if (poll_cnt != 8'hFF)
							poll_cnt++;
						if (poll_cnt >= poll_limit)
							end_with_error(PH_END_TIMEOUT);
					end else begin
						case (seq_phase)
							PH_C0_POLL: begin
								if (rx == R1_IDLE)
									enter_phase(PH_C0_GAP);
								else
									end_with_error(PH_END_NOTSD);
							end
							PH_C8_POLL: begin
								// illegal command here marks a v1 card
								if ((rx & R1_ILLEGAL) != 0) begin
									card_kind = CT_SD1;
									enter_phase(PH_C8_GAP);
								end else begin
									card_kind = CT_UNKNOWN;
									enter_phase(PH_C8_TRAIL);
								end
							end
							PH_OCR1_POLL: begin
								if ((rx & R1_ILLEGAL) != 0)
									end_with_error(PH_END_NOTSD);
								else
									enter_phase(PH_OCR1_TRAIL);
							end
							PH_C55_POLL: begin
								if ((rx & R1_ILLEGAL) != 0)
									end_with_error(PH_END_NOTSD);
								else
									enter_phase(PH_C55_GAP);
							end
							PH_A41_POLL: begin
								if ((rx & R1_IDLE) != 0)
									enter_phase(PH_LOOP_GAP);
								else if (card_kind == CT_SD1)
									enter_phase(PH_END_OK);
								else
									enter_phase(PH_OCR2_SEND);
							end
							default: enter_phase(PH_OCR2_TRAIL);
						endcase
					end
				end
				PH_C8_TRAIL, PH_OCR1_TRAIL, PH_OCR2_TRAIL: begin
					// CCS sits in the first OCR byte of the second read
					if (seq_phase == PH_OCR2_TRAIL && slot_idx == 4'd0) begin
						if ((rx & OCR_CCS) != 0)
							card_kind = CT_SDHC;
						else
							card_kind = CT_SD2;
					end
					slot_idx++;
					if (slot_idx >= TRAIL_LEN) begin
						case (seq_phase)
							PH_C8_TRAIL:   enter_phase(PH_C8_GAP);
							PH_OCR1_TRAIL: enter_phase(PH_LOOP_GAP);
							default:       enter_phase(PH_END_OK);
						endcase
					end
				end
				PH_C0_GAP:   enter_phase(PH_C8_SEND);
				PH_C8_GAP:   enter_phase(PH_OCR1_SEND);
				PH_LOOP_GAP: enter_phase(PH_C55_SEND);
				PH_C55_GAP:  enter_phase(PH_A41_SEND);
				default: begin
					// command bytes; the frame is followed by its poll
					slot_idx++;
					if (slot_idx >= CMD_LEN) begin
						case (seq_phase)
							PH_C0_SEND:   enter_phase(PH_C0_POLL);
							PH_C8_SEND:   enter_phase(PH_C8_POLL);
							PH_OCR1_SEND: enter_phase(PH_OCR1_POLL);
							PH_C55_SEND:  enter_phase(PH_C55_POLL);
							PH_A41_SEND:  enter_phase(PH_A41_POLL);
							default:      enter_phase(PH_OCR2_POLL);
						endcase
					end
				end
			endcase
		end

		// Result word
		running = seq_phase != PH_IDLE && !is_end(seq_phase);
		word    = '0;
		if (running) begin
			case (seq_phase)
				PH_C0_SEND:                 row = FR_CMD0;
				PH_C8_SEND:                 row = FR_CMD8;
				PH_OCR1_SEND, PH_OCR2_SEND: row = FR_CMD58;
				PH_C55_SEND:                row = FR_CMD55;
				PH_A41_SEND:                row = FR_ACMD41;
				default:                    row = -1;
			endcase
			if (row < 0)
				word.tx_byte = BYTE_FILL;
			else
				word.tx_byte = CMD_FRAMES[row][47 - 8 * int'(slot_idx) -: 8];
		end
		word.select_active = running && seq_phase != PH_DUMMY;
		word.power_enable  = running;
		word.finished      = is_end(seq_phase);
		if (seq_phase == PH_END_TIMEOUT)
			word.status = ST_TIMEOUT;
		else if (seq_phase == PH_END_NOTSD)
			word.status = ST_NOT_SD;
		word.card_type = card_kind;
		return word;
	endfunction

	// ------------------------------------------------------------------
	// Idling and reporting
	// ------------------------------------------------------------------
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got_v,
	                               input logic [15:0] exp_v);
		if (mismatches < 40)
			$display("%0t: %s mismatch, got %h expected %h", $time, what, got_v, exp_v);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Card script
	// ------------------------------------------------------------------
	task automatic push_slot(input logic mode, input logic [7:0] rx);
		slot_t s;
		if (sess_left == 0)
			return;
		sess_left--;
		s.mode = mode;
		s.rx   = rx;
		slots_to_send.push_back(s);
		items_queued++;
	endtask

	// Bytes clocked in while a command goes out: mostly fill
	task automatic send_command();
		repeat (CMD_LEN)
			push_slot(MODE_XFER, ($urandom_range(0, 3) == 0) ? 8'($urandom) : BYTE_FILL);
	endtask

	// Random R1 byte with given bits forced; never the fill byte
	function automatic logic [7:0] r1_byte(input logic [7:0] set_bits,
	                                       input logic [7:0] clr_bits);
		logic [7:0] b;
		b = 8'($urandom);
		b = (b & ~clr_bits) | set_bits;
		if (b == BYTE_FILL)
			b = b & 8'h7F;
		return b;
	endfunction

	// Some fill bytes, then the reply, unless the limit is run out
	task automatic card_poll(input logic [7:0] resp, output bit timed_out);
		int lim, fills;
		lim = (poll_limit == 8'd0) ? 1 : int'(poll_limit);
		if ($urandom_range(0, 99) < ((lim <= 8) ? 5 : 1))
			fills = lim;
		else if ($urandom_range(0, 24) == 0)
			fills = $urandom_range(0, lim - 1);
		else
			fills = $urandom_range(0, (lim > 4) ? 3 : lim - 1);
		repeat (fills)
			push_slot(MODE_XFER, BYTE_FILL);
		timed_out = fills == lim;
		if (!timed_out)
			push_slot(MODE_XFER, resp);
	endtask

	// One start-up attempt against a card of random kind and behaviour
	task automatic card_session();
		logic [7:0] resp;
		bit         timed_out, is_v1, bad;
		int         loops;
		sess_left = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 60) : SESSION_ANY;
		push_slot(MODE_START, 8'($urandom));
		repeat (DUMMY_BYTES)
			push_slot(MODE_XFER, 8'($urandom));

		// CMD0: anything but a clean idle reply ends the run
		send_command();
		if ($urandom_range(0, 9) == 0) begin
			resp = r1_byte(8'h00, 8'h00);
			if (resp == R1_IDLE)
				resp = BYTE_NONE;
		end else begin
			resp = R1_IDLE;
		end
		card_poll(resp, timed_out);
		if (timed_out || resp != R1_IDLE)
			return;
		push_slot(MODE_XFER, 8'($urandom));

		// CMD8: v1 cards reject it, v2 cards send four random trailing bytes
		send_command();
		is_v1 = $urandom_range(0, 2) == 0;
		card_poll(is_v1 ? r1_byte(R1_ILLEGAL, 8'h00) : r1_byte(8'h00, R1_ILLEGAL), timed_out);
		if (timed_out)
			return;
		if (!is_v1)
			repeat (TRAIL_LEN)
				push_slot(MODE_XFER, 8'($urandom));
		push_slot(MODE_XFER, 8'($urandom));

		// CMD58: rejection means not an SD card
		send_command();
		bad = $urandom_range(0, 11) == 0;
		card_poll(bad ? r1_byte(R1_ILLEGAL, 8'h00) : r1_byte(8'h00, R1_ILLEGAL), timed_out);
		if (timed_out || bad)
			return;
		repeat (TRAIL_LEN)
			push_slot(MODE_XFER, 8'($urandom));

		// CMD55/ACMD41 loop while the card stays idle
		loops = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 2);
		for (int i = 0; i <= loops; i++) begin
			push_slot(MODE_XFER, 8'($urandom));
			send_command();
			bad = $urandom_range(0, 19) == 0;
			card_poll(bad ? r1_byte(R1_ILLEGAL, 8'h00) : r1_byte(8'h00, R1_ILLEGAL),
			          timed_out);
			if (timed_out || bad)
				return;
			push_slot(MODE_XFER, 8'($urandom));
			send_command();
			card_poll((i < loops) ? r1_byte(R1_IDLE, 8'h00) : r1_byte(8'h00, R1_IDLE),
			          timed_out);
			if (timed_out)
				return;
		end

		// v2 cards: second OCR read for the capacity bit
		if (!is_v1) begin
			send_command();
			card_poll(r1_byte(8'h00, 8'h00), timed_out);
			if (timed_out)
				return;
			repeat (TRAIL_LEN)
				push_slot(MODE_XFER, 8'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_poll_limit(input logic [7:0] v);
		wait_drained();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		poll_limit = v;
	endtask

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------
	initial begin
		int first;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: exchanges before any start are ignored, restart mid-run
		push_slot(MODE_XFER, 8'h00);
		push_slot(MODE_XFER, 8'hFF);
		push_slot(MODE_XFER, 8'h5A);
		push_slot(MODE_START, 8'hFF);
		repeat (3)
			push_slot(MODE_XFER, 8'hA5);
		push_slot(MODE_START, 8'h00);
		repeat (2)
			push_slot(MODE_XFER, 8'hFF);

		// Random sessions under several poll limits, reset value first
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: set_poll_limit(8'd1);
				2: set_poll_limit(8'd0);
				3: set_poll_limit(8'd255);
				4: set_poll_limit(8'd2);
				5: set_poll_limit(8'($urandom_range(3, 254)));
				default: ;
			endcase
			first = items_queued;
			while (items_queued - first < PHASE_WORDS) begin
				if ($urandom_range(0, 7) == 0) begin
					sess_left = SESSION_ANY;
					repeat ($urandom_range(3, 12))
						push_slot(($urandom_range(0, 4) == 0) ? MODE_START : MODE_XFER,
						          8'($urandom));
				end else begin
					card_session();
				end
				// stray exchanges after each session or burst
				sess_left = SESSION_ANY;
				repeat ($urandom_range(0, 2))
					push_slot(MODE_XFER, 8'($urandom));
			end
		end

		wait_drained();
		repeat (6) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Slave side driver: next word at the falling edge
	always @(negedge clk) begin : drive_slots
		slot_t nxt;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (in_gap > 0 || slots_to_send.size() == 0) begin
				if (in_gap > 0)
					in_gap--;
				s_tvalid <= 1'b0;
			end else begin
				nxt = slots_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= nxt.mode;
				s_tdata  <= nxt.rx;
				in_gap   = idle_len();
			end
		end
	end

	// Master side backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				out_stall = idle_len();
			end
		end
	end

	// Accepted slave word: predict its result
	always @(posedge clk) begin
		in_taken = s_tvalid && s_tready;
		if (arst_n && in_taken) begin
			results_due.push_back(step_sequencer(s_tuser, s_tdata));
			items_taken++;
		end
	end

	// Accepted master word: check against the oldest prediction
	always @(posedge clk) begin : check_results
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, 16'h0000);
			end else begin
				want = results_due.pop_front();
				got  = result_t'(m_tdata[14:0]);
				if (got.tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", m_tdata, {1'b0, want});
				if (got.select_active !== want.select_active)
					report_mismatch("select_active", m_tdata, {1'b0, want});
				if (got.power_enable !== want.power_enable)
					report_mismatch("power_enable", m_tdata, {1'b0, want});
				if (got.finished !== want.finished)
					report_mismatch("finished", m_tdata, {1'b0, want});
				if (got.status !== want.status)
					report_mismatch("status", m_tdata, {1'b0, want});
				if (got.card_type !== want.card_type)
					report_mismatch("card_type", m_tdata, {1'b0, want});
				if (m_tdata[15] !== 1'b0)
					report_mismatch("padding", m_tdata, {1'b0, want});
			end
		end
	end

	// Run limit; also switches idle-free stretches on and off
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 256 == 0)
			calm = $urandom_range(0, 3) == 0;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
